[design/der_rsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_pkg: shared types and constants of the DER RSA public key parser
// Parse phases, element codes, status codes and the result record that the
// front end hands to the output stage.
// ----------------------------------------------------------------------------
package der_rsa_pkg;

   // Sizes
   localparam int WORD_W            = 32;
   localparam int LEVELS            = 5;
   localparam int LEVEL_IDX_W       = $clog2(LEVELS);
   localparam int OPEN_W            = $clog2(LEVELS + 1);
   localparam int DEF_LENGTH_BYTES  = 4;
   localparam int DEF_QUEUE_DEPTH   = 4;
   localparam int RSP_DATA_W        = 80;
   localparam int KIND_W            = 2;
   localparam int STATUS_W          = 3;

   // DER tags and the bit string pad byte
   localparam logic [7:0] TAG_SEQ   = 8'h30;
   localparam logic [7:0] TAG_INT   = 8'h02;
   localparam logic [7:0] TAG_BITS  = 8'h03;
   localparam logic [7:0] PAD_ZERO  = 8'h00;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_MOD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TAG      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LEN_FORM = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_INT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PAD      = 3'd5;

   typedef enum logic [2:0] {
      PH_TAG, PH_LEN1, PH_LENX, PH_SKIP, PH_PAD, PH_INT, PH_DONE, PH_ERR
   } phase_type;

   typedef enum logic [2:0] {
      EL_OUTER, EL_FIRST, EL_ALG, EL_BIT, EL_INNER, EL_MOD, EL_EXP
   } elem_type;

   // Remaining byte count of each open nesting level, outermost at 0
   typedef logic [LEVELS-1:0][WORD_W-1:0] level_arr_type;

   // One queued event: an optional content byte, then an optional status
   typedef struct packed {
      logic                  has_byte;
      logic                  is_exp;
      logic [7:0]            data;
      logic                  has_status;
      logic [STATUS_W-1:0]   status;
      logic [WORD_W-1:0]     mod_len;
      logic [WORD_W-1:0]     exp_len;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[design/der_rsa_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_front: DER header walker
// Takes one key byte a cycle unless the queue is full, tracks tags,
// lengths and nesting, pushes event records per kept byte and closing status.
// ----------------------------------------------------------------------------
module der_rsa_front #(
   parameter int LENGTH_BYTES = der_rsa_pkg::DEF_LENGTH_BYTES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] byte_in
   input  wire logic                          req_tlast,   // last_in
   output logic                               push,
   output der_rsa_pkg::rec_type               push_rec,
   input  wire der_rsa_pkg::queue_status_type q_status
);
   import der_rsa_pkg::*;

   localparam int ACC_W  = 8 * LENGTH_BYTES;
   localparam int LEFT_W = $clog2(LENGTH_BYTES + 1);

   // State
   phase_type                phase_ff, phase_in, ph_s;
   elem_type                 elem_ff, elem_in, el_s;
   level_arr_type            lvl_ff, lvl_in, lv_s;
   logic [OPEN_W-1:0]        open_ff, open_in, op_s;
   logic [ACC_W-1:0]         acc_ff, acc_in, acc_s;
   logic [LEFT_W-1:0]        left_ff, left_in, left_s;
   logic                     lz_ff, lz_in, lz_s;
   logic [WORD_W-1:0]        mc_ff, mc_in, mc_s;
   logic [WORD_W-1:0]        ec_ff, ec_in, ec_s;
   logic [STATUS_W-1:0]      err_ff, err_in, err_s;

   logic                     take;
   logic [7:0]               b;
   logic                     do_hdr;
   logic [WORD_W-1:0]        hlen;
   logic [6:0]               cnt;
   logic [7:0]               want;
   logic                     emit;
   logic [STATUS_W-1:0]      st;

   function automatic logic [WORD_W-1:0] top_of(level_arr_type lv,
                                                logic [OPEN_W-1:0] op);
      logic [WORD_W-1:0] r;
      r = '0;
      if (op != '0)
         r = lv[LEVEL_IDX_W'(op - OPEN_W'(1))];
      return r;
   endfunction

   // every open level loses one byte, saturating at zero
   function automatic level_arr_type consume(level_arr_type lv,
                                             logic [OPEN_W-1:0] op);
      level_arr_type r;
      r = lv;
      for (int i = 0; i < LEVELS; i++)
         if (OPEN_W'(i) < op && r[i] != '0)
            r[i] = r[i] - WORD_W'(1);
      return r;
   endfunction

   assign take       = req_tvalid && req_tready;
   assign req_tready = !q_status.full;
   assign b          = req_tdata;

   // Next state
   always_comb begin
      ph_s   = phase_ff;
      el_s   = elem_ff;
      lv_s   = lvl_ff;
      op_s   = open_ff;
      acc_s  = acc_ff;
      left_s = left_ff;
      lz_s   = lz_ff;
      mc_s   = mc_ff;
      ec_s   = ec_ff;
      err_s  = err_ff;
      do_hdr = 1'b0;
      hlen   = '0;
      cnt    = '0;
      want   = TAG_SEQ;
      emit   = 1'b0;
      unique case (phase_ff) inside
         PH_TAG, PH_LEN1, PH_LENX: begin
            if (open_ff != '0 && top_of(lvl_ff, open_ff) == '0) begin
               err_s = ST_SHORT;
               ph_s  = PH_ERR;
            end else begin
               lv_s = consume(lvl_ff, open_ff);
               if (phase_ff == PH_TAG) begin
                  if (elem_ff == EL_FIRST) begin
                     // first inner tag picks the key form
                     if (b == TAG_INT) begin
                        el_s = EL_MOD;
                        ph_s = PH_LEN1;
                     end else if (b == TAG_SEQ) begin
                        el_s = EL_ALG;
                        ph_s = PH_LEN1;
                     end else begin
                        err_s = ST_TAG;
                        ph_s  = PH_ERR;
                     end
                  end else begin
                     if (elem_ff == EL_BIT)
                        want = TAG_BITS;
                     else if (elem_ff == EL_MOD || elem_ff == EL_EXP)
                        want = TAG_INT;
                     if (b == want) begin
                        ph_s = PH_LEN1;
                     end else begin
                        err_s = ST_TAG;
                        ph_s  = PH_ERR;
                     end
                  end
               end else if (phase_ff == PH_LEN1) begin
                  if (b[7]) begin
                     cnt = b[6:0];
                     if (cnt == '0 || cnt > 7'(LENGTH_BYTES)) begin
                        err_s = ST_LEN_FORM;
                        ph_s  = PH_ERR;
                     end else begin
                        acc_s  = '0;
                        left_s = LEFT_W'(cnt);
                        ph_s   = PH_LENX;
                     end
                  end else begin
                     do_hdr = 1'b1;
                     hlen   = WORD_W'(b);
                  end
               end else begin
                  acc_s = ACC_W'({acc_ff, b});
                  if (left_s != '0)
                     left_s = left_s - LEFT_W'(1);
                  if (left_s == '0) begin
                     do_hdr = 1'b1;
                     hlen   = WORD_W'(acc_s);
                  end
               end
            end
         end
         PH_SKIP: begin
            lv_s = consume(lvl_ff, open_ff);
            if (top_of(lv_s, open_ff) == '0) begin
               op_s = open_ff - OPEN_W'(1);
               el_s = EL_BIT;
               ph_s = PH_TAG;
            end
         end
         PH_PAD: begin
            lv_s = consume(lvl_ff, open_ff);
            if (b != PAD_ZERO) begin
               err_s = ST_PAD;
               ph_s  = PH_ERR;
            end else begin
               el_s = EL_INNER;
               ph_s = PH_TAG;
            end
         end
         PH_INT: begin
            lv_s = consume(lvl_ff, open_ff);
            if (!(lz_ff && b == PAD_ZERO)) begin
               lz_s = 1'b0;
               emit = 1'b1;
               if (elem_ff == EL_EXP)
                  ec_s = ec_ff + WORD_W'(1);
               else
                  mc_s = mc_ff + WORD_W'(1);
            end
            if (top_of(lv_s, open_ff) == '0) begin
               if (lz_s) begin
                  err_s = ST_ZERO_INT;
                  ph_s  = PH_ERR;
               end else begin
                  op_s = open_ff - OPEN_W'(1);
                  if (elem_ff == EL_EXP) begin
                     ph_s = PH_DONE;
                  end else begin
                     el_s = EL_EXP;
                     ph_s = PH_TAG;
                  end
               end
            end
         end
         PH_DONE: begin
            if (lvl_ff[0] != '0)
               lv_s[0] = lvl_ff[0] - WORD_W'(1);
         end
         PH_ERR: begin
         end
         default: begin
         end
      endcase

      // header complete: open a level and move on per element
      if (do_hdr) begin
         if (open_ff != '0 && hlen > top_of(lv_s, open_ff)) begin
            err_s = ST_SHORT;
            ph_s  = PH_ERR;
         end else if (open_ff >= OPEN_W'(LEVELS)) begin
            err_s = ST_SHORT;
            ph_s  = PH_ERR;
         end else begin
            lv_s[LEVEL_IDX_W'(open_ff)] = hlen;
            op_s = open_ff + OPEN_W'(1);
            case (elem_ff)
               EL_OUTER: begin
                  el_s = EL_FIRST;
                  ph_s = PH_TAG;
               end
               EL_ALG: begin
                  if (hlen == '0) begin
                     op_s = open_ff;
                     el_s = EL_BIT;
                     ph_s = PH_TAG;
                  end else begin
                     ph_s = PH_SKIP;
                  end
               end
               EL_BIT: begin
                  if (hlen == '0) begin
                     err_s = ST_SHORT;
                     ph_s  = PH_ERR;
                  end else begin
                     ph_s = PH_PAD;
                  end
               end
               EL_INNER: begin
                  el_s = EL_MOD;
                  ph_s = PH_TAG;
               end
               default: begin
                  if (hlen == '0) begin
                     err_s = ST_ZERO_INT;
                     ph_s  = PH_ERR;
                  end else begin
                     lz_s = 1'b1;
                     ph_s = PH_INT;
                  end
               end
            endcase
         end
      end

      // the last byte returns everything to the reset state
      if (req_tlast) begin
         phase_in = PH_TAG;
         elem_in  = EL_OUTER;
         lvl_in   = '0;
         open_in  = '0;
         acc_in   = '0;
         left_in  = '0;
         lz_in    = 1'b1;
         mc_in    = '0;
         ec_in    = '0;
         err_in   = ST_OK;
      end else begin
         phase_in = ph_s;
         elem_in  = el_s;
         lvl_in   = lv_s;
         open_in  = op_s;
         acc_in   = acc_s;
         left_in  = left_s;
         lz_in    = lz_s;
         mc_in    = mc_s;
         ec_in    = ec_s;
         err_in   = err_s;
      end
   end

   // Event record
   always_comb begin
      st = err_s;
      if (st == ST_OK && (ph_s != PH_DONE || lv_s[0] != '0))
         st = ST_SHORT;
      push                = take && (emit || req_tlast);
      push_rec.has_byte   = emit;
      push_rec.is_exp     = (elem_ff == EL_EXP);
      push_rec.data       = b;
      push_rec.has_status = req_tlast;
      push_rec.status     = st;
      push_rec.mod_len    = mc_s;
      push_rec.exp_len    = ec_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         elem_ff  <= EL_OUTER;
         lvl_ff   <= '0;
         open_ff  <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         lz_ff    <= 1'b1;
         mc_ff    <= '0;
         ec_ff    <= '0;
         err_ff   <= ST_OK;
      end else if (take) begin
         phase_ff <= phase_in;
         elem_ff  <= elem_in;
         lvl_ff   <= lvl_in;
         open_ff  <= open_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         lz_ff    <= lz_in;
         mc_ff    <= mc_in;
         ec_ff    <= ec_in;
         err_ff   <= err_in;
      end
   end

   // Checks
   a_err_has_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |-> err_ff != ST_OK)
      else $error("error phase without an error code");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OPEN_W'(LEVELS))
      else $error("nesting depth beyond level stack");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      take && req_tlast |=> phase_ff == PH_TAG && open_ff == '0 && mc_ff == '0)
      else $error("parser not back at start after last word");

endmodule

`default_nettype wire

[design/der_rsa_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_queue: event queue between parser and output stage
// Small register FIFO of event records; head is read in place.
// ----------------------------------------------------------------------------
module der_rsa_queue #(
   parameter int QUEUE_DEPTH = der_rsa_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire der_rsa_pkg::rec_type     push_rec,
   input  wire logic                     pop,
   output der_rsa_pkg::rec_type          head_rec,
   output der_rsa_pkg::queue_status_type q_status
);
   import der_rsa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_rec       = entry_ff[rd_ff];
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;

   // Pointer and fill update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

[design/der_rsa_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_back: result output stage
// Turns each queued event into one or two result words and holds them in
// the output register until taken.
// ----------------------------------------------------------------------------
module der_rsa_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire der_rsa_pkg::rec_type                  head_rec,
   input  wire der_rsa_pkg::queue_status_type         q_status,
   output logic                                       pop,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [7:0] data_byte, [10:8] status, [42:11] modulus_len,
   // [74:43] exponent_len, [79:75] zero
   output logic [der_rsa_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [der_rsa_pkg::KIND_W-1:0]             rsp_tuser,  // [1:0] kind
   output logic                                       rsp_tlast   // last_out
);
   import der_rsa_pkg::*;

   logic                    valid_ff, valid_in;
   logic [RSP_DATA_W-1:0]   data_ff, data_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic                    last_ff, last_in;
   logic                    byte_sent_ff, byte_sent_in;
   logic                    load;
   logic                    need_byte;

   assign load      = !valid_ff || rsp_tready;
   assign need_byte = head_rec.has_byte && !byte_sent_ff;

   // Result selection: content byte first, status after it
   always_comb begin
      valid_in     = valid_ff;
      data_in      = data_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      byte_sent_in = byte_sent_ff;
      pop          = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (need_byte) begin
               data_in      = RSP_DATA_W'(head_rec.data);
               kind_in      = head_rec.is_exp ? KIND_EXP : KIND_MOD;
               last_in      = 1'b0;
               byte_sent_in = head_rec.has_status;
               pop          = !head_rec.has_status;
            end else begin
               data_in      = RSP_DATA_W'({head_rec.exp_len, head_rec.mod_len,
                                           head_rec.status, 8'h00});
               kind_in      = KIND_STATUS;
               last_in      = 1'b1;
               byte_sent_in = 1'b0;
               pop          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         byte_sent_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         byte_sent_ff <= byte_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // Checks
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> last_ff == (kind_ff == KIND_STATUS))
      else $error("tlast and status kind disagree");

   a_byte_no_lengths: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != KIND_STATUS |-> data_ff[RSP_DATA_W-1:8] == '0)
      else $error("byte word carries status fields");

   a_split_pending: assert property (@(posedge clock) disable iff (reset)
      byte_sent_ff |-> !q_status.empty && head_rec.has_status)
      else $error("split event lost its queue entry");

endmodule

`default_nettype wire

[design/der_rsa_public_key_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_public_key_parser: streaming DER RSA public key parser
// Walks PKCS#1 or SubjectPublicKeyInfo DER bytes, streams modulus and
// exponent bytes without leading zeros and closes each key with a status.
// ----------------------------------------------------------------------------
//  Port group | Direction | Moves
//  req_*      | in        | one DER byte a word, tlast on the final byte
//  rsp_*      | out       | modulus/exponent byte or final status (tuser kind)
//
//  The parser takes one byte per cycle while the queue is not full; its loop
//  is a registered update of the tag/length/level state. A byte that yields
//  a content byte and a status occupies the output register for two words.
//  A result word is registered in an event queue of QUEUE_DEPTH and then in
//  the output register before it is offered on rsp. Synchronous reset clears
//  parser, queue and output valid; the final byte of a key also returns the
//  parser to its start. A stalled rsp fills the queue, and req_tready drops
//  only when the queue is full.
// ----------------------------------------------------------------------------
module der_rsa_public_key_parser #(
   parameter int LENGTH_BYTES = der_rsa_pkg::DEF_LENGTH_BYTES,
   parameter int QUEUE_DEPTH  = der_rsa_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] byte_in
   input  wire logic                               req_tlast,  // last_in
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] data_byte, [10:8] status, [42:11] modulus_len,
   // [74:43] exponent_len, [79:75] zero
   output logic [der_rsa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [der_rsa_pkg::KIND_W-1:0]          rsp_tuser,  // [1:0] kind
   output logic                                    rsp_tlast   // last_out
);
   import der_rsa_pkg::*;

   logic              push;
   rec_type           push_rec;
   logic              pop;
   rec_type           head_rec;
   queue_status_type  q_status;

   der_rsa_front #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_rec   (push_rec),
      .q_status   (q_status)
   );

   der_rsa_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   der_rsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the DER RSA public key parser
// Feeds DER keys in both accepted forms, plus broken and noisy ones, one byte
// per word, and checks every result word against a byte-level model of the
// parser. Both stream sides idle at random, and long output hold-offs in two of
// the three random phases fill the internal queue so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import der_rsa_pkg::*;

   typedef logic [7:0] byte_q_type [$];

   // One result word as the parser should emit it
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [7:0]          data;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   mod_len;
      logic [WORD_W-1:0]   exp_len;
      logic                last;
   } key_word_type;

   // Directed row: one DER byte, and a typed status where it is obvious
   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      logic                typed;
      logic [STATUS_W-1:0] status;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam int PHASE_WORDS   = 470;
   localparam int HOLD_OFF      = 400;
   localparam int DRAIN_CYCLES  = 16;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] byte_in
   logic                  req_tlast;   // last_in
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] data_byte, [10:8] status, [42:11] modulus_len,
   // [74:43] exponent_len, [79:75] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;   // [1:0] kind
   logic                  rsp_tlast;   // last_out

   key_word_type expected_key_words [$];
   int unsigned  error_count = 0;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  hold_off_left = 0;

   // Model state of the parser
   phase_type         key_phase;
   elem_type          next_elem;
   logic              key_spki;
   logic [WORD_W-1:0] level_left [LEVELS];
   int unsigned       open_count;
   logic [WORD_W-1:0] len_acc;
   int unsigned       len_bytes;
   logic              leading_zero;
   logic [WORD_W-1:0] mod_count;
   logic [WORD_W-1:0] exp_count;
   logic [2:0]        err_code;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // wrong outer tag
      '{8'h31, 1'b1, 1'b1, ST_TAG},
      // long form with no length bytes
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h80, 1'b1, 1'b1, ST_LEN_FORM},
      // modulus of length zero
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h03, 1'b0, 1'b0, ST_OK},
      '{8'h02, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b1, ST_ZERO_INT},
      // minimal PKCS#1 key, outer length in long form
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h82, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h06, 1'b0, 1'b0, ST_OK},
      '{8'h02, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, ST_OK},
      '{8'h02, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b0, 1'b0, ST_OK},
      '{8'h03, 1'b1, 1'b0, ST_OK},
      // empty outer sequence, ends early
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b1, ST_SHORT},
      // SPKI with empty alg and a nonzero bit string pad
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h05, 1'b0, 1'b0, ST_OK},
      '{8'h30, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h03, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b1, 1'b1, ST_PAD}
   };

   der_rsa_public_key_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------
   function automatic void restart_key();
      key_phase    = PH_TAG;
      next_elem    = EL_OUTER;
      key_spki     = 1'b0;
      for (int i = 0; i < LEVELS; i++) level_left[i] = '0;
      open_count   = 0;
      len_acc      = '0;
      len_bytes    = 0;
      leading_zero = 1'b1;
      mod_count    = '0;
      exp_count    = '0;
      err_code     = ST_OK;
   endfunction

   function automatic void latch_error(input logic [2:0] code);
      err_code  = code;
      key_phase = PH_ERR;
   endfunction

   // every open level loses one byte
   function automatic void take_byte();
      for (int i = 0; i < open_count && i < LEVELS; i++)
         if (level_left[i] > 0) level_left[i]--;
   endfunction

   function automatic logic [WORD_W-1:0] inner_left();
      if (open_count == 0 || open_count > LEVELS) return '0;
      return level_left[open_count-1];
   endfunction

   // length of an element known: open a level, pick the next phase
   function automatic void open_element(input logic [WORD_W-1:0] len);
      if (open_count > 0 && len > inner_left()) begin
         latch_error(ST_SHORT);
         return;
      end
      if (open_count >= LEVELS) begin
         latch_error(ST_SHORT);
         return;
      end
      level_left[open_count] = len;
      open_count++;
      case (next_elem)
         EL_OUTER: begin
            next_elem = EL_FIRST;
            key_phase = PH_TAG;
         end
         EL_ALG: begin
            if (len == 0) begin
               open_count--;
               next_elem = EL_BIT;
               key_phase = PH_TAG;
            end else begin
               key_phase = PH_SKIP;
            end
         end
         EL_BIT: begin
            if (len == 0) latch_error(ST_SHORT);
            else key_phase = PH_PAD;
         end
         EL_INNER: begin
            next_elem = EL_MOD;
            key_phase = PH_TAG;
         end
         default: begin
            if (len == 0) begin
               latch_error(ST_ZERO_INT);
            end else begin
               leading_zero = 1'b1;
               key_phase    = PH_INT;
            end
         end
      endcase
   endfunction

   // one accepted DER byte: advance the model, queue what it emits
   function automatic void predict_key_word(input logic [7:0] data, input logic last);
      logic [7:0]          tag_needed;
      logic [2:0]          code;
      int unsigned         cnt;
      key_word_type        w;
      case (key_phase) inside
         PH_TAG, PH_LEN1, PH_LENX: begin
            if (open_count > 0 && inner_left() == 0) begin
               latch_error(ST_SHORT);
            end else begin
               take_byte();
               if (key_phase == PH_TAG) begin
                  if (next_elem == EL_FIRST) begin
                     if (data == TAG_INT) begin
                        key_spki  = 1'b0;
                        next_elem = EL_MOD;
                        key_phase = PH_LEN1;
                     end else if (data == TAG_SEQ) begin
                        key_spki  = 1'b1;
                        next_elem = EL_ALG;
                        key_phase = PH_LEN1;
                     end else begin
                        latch_error(ST_TAG);
                     end
                  end else begin
                     if (next_elem == EL_BIT) tag_needed = TAG_BITS;
                     else if (next_elem == EL_MOD || next_elem == EL_EXP) tag_needed = TAG_INT;
                     else tag_needed = TAG_SEQ;
                     if (data == tag_needed) key_phase = PH_LEN1;
                     else latch_error(ST_TAG);
                  end
               end else if (key_phase == PH_LEN1) begin
                  if (data[7]) begin
                     cnt = 32'(data[6:0]);
                     if (cnt == 0 || cnt > DEF_LENGTH_BYTES || cnt > 4) begin
                        latch_error(ST_LEN_FORM);
                     end else begin
                        len_acc   = '0;
                        len_bytes = cnt;
                        key_phase = PH_LENX;
                     end
                  end else begin
                     open_element({24'd0, data});
                  end
               end else begin
                  len_acc = {len_acc[23:0], data};
                  if (len_bytes > 0) len_bytes--;
                  if (len_bytes == 0) open_element(len_acc);
               end
            end
         end
         PH_SKIP: begin
            take_byte();
            if (inner_left() == 0) begin
               open_count--;
               next_elem = EL_BIT;
               key_phase = PH_TAG;
            end
         end
         PH_PAD: begin
            take_byte();
            if (data != PAD_ZERO) begin
               latch_error(ST_PAD);
            end else begin
               next_elem = EL_INNER;
               key_phase = PH_TAG;
            end
         end
         PH_INT: begin
            take_byte();
            if (!(leading_zero && data == 8'h00)) begin
               leading_zero = 1'b0;
               w = '{(next_elem == EL_EXP) ? KIND_EXP : KIND_MOD, data, ST_OK, '0, '0, 1'b0};
               expected_key_words.push_back(w);
               if (next_elem == EL_EXP) exp_count++;
               else mod_count++;
            end
            if (inner_left() == 0) begin
               if (leading_zero) begin
                  latch_error(ST_ZERO_INT);
               end else begin
                  if (open_count > 0) open_count--;
                  if (next_elem == EL_EXP) begin
                     key_phase = PH_DONE;
                  end else begin
                     next_elem = EL_EXP;
                     key_phase = PH_TAG;
                  end
               end
            end
         end
         PH_DONE: begin
            if (level_left[0] > 0) level_left[0]--;
         end
         default: ;
      endcase

      // final status, then back to the start state
      if (last) begin
         code = err_code;
         if (code == ST_OK && (key_phase != PH_DONE || level_left[0] > 0)) code = ST_SHORT;
         w = '{KIND_STATUS, 8'h00, code, mod_count, exp_count, 1'b1};
         expected_key_words.push_back(w);
         restart_key();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Key construction
   // ---------------------------------------------------------------------
   // prefix tag and length; the length form is picked at random
   task automatic wrap_element(ref byte_q_type el, input logic [7:0] tag);
      byte_q_type  hdr;
      int unsigned n;
      int unsigned nb;
      n = el.size();
      hdr.push_back(tag);
      if (n < 128 && $urandom_range(3) != 0) begin
         hdr.push_back(8'(n));
      end else begin
         nb = (n < 256) ? 1 : (n < 65536) ? 2 : 3;
         nb = $urandom_range(4, nb);
         hdr.push_back(8'h80 | 8'(nb));
         for (int i = int'(nb) - 1; i >= 0; i--) hdr.push_back(8'(n >> (8 * i)));
      end
      el = {hdr, el};
   endtask

   task automatic make_integer(ref byte_q_type el, input int unsigned body_len,
                               input int unsigned lz, input bit all_zero);
      el.delete();
      repeat (lz) el.push_back(8'h00);
      repeat (body_len) el.push_back(all_zero ? 8'h00 : 8'($urandom));
      wrap_element(el, TAG_INT);
   endtask

   // mostly well-formed keys of either form, some broken, a few pure noise
   task automatic make_key(ref byte_q_type key);
      byte_q_type  modulus;
      byte_q_type  exponent;
      byte_q_type  body;
      byte_q_type  alg;
      int unsigned pick;
      int unsigned cut;
      key.delete();
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(24, 1)) key.push_back(8'($urandom));
         return;
      end
      make_integer(modulus,
                   ($urandom_range(15) == 0) ? $urandom_range(300, 120) : $urandom_range(24, 1),
                   $urandom_range(2), $urandom_range(29) == 0);
      make_integer(exponent,
                   ($urandom_range(15) == 0) ? 0 : $urandom_range(4, 1),
                   $urandom_range(1), 1'b0);
      body = {modulus, exponent};
      if ($urandom_range(1) != 0) begin
         // SPKI: inner sequence inside a bit string, behind an alg sequence
         wrap_element(body, TAG_SEQ);
         body.push_front(PAD_ZERO);
         wrap_element(body, TAG_BITS);
         repeat ($urandom_range(10)) alg.push_back(8'($urandom));
         wrap_element(alg, TAG_SEQ);
         body = {alg, body};
      end
      // trailing bytes inside the outer sequence
      if ($urandom_range(5) == 0) repeat ($urandom_range(4, 1)) body.push_back(8'($urandom));
      wrap_element(body, TAG_SEQ);
      key = body;
      // trailing bytes past the outer sequence
      if ($urandom_range(5) == 0) repeat ($urandom_range(3, 1)) key.push_back(8'($urandom));
      pick = $urandom_range(99);
      if (pick < 12) begin
         key[$urandom_range(key.size() - 1)] = 8'($urandom);
      end else if (pick < 20) begin
         cut = $urandom_range(key.size() - 1, 1);
         while (key.size() > cut) void'(key.pop_back());
      end
   endtask

   // ---------------------------------------------------------------------
   // Input side: drive at falling edge, accept at rising edge
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] data, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_key_word(data, last);
   endtask

   // ---------------------------------------------------------------------
   // Output side: ready at random, long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string what, input logic [WORD_W-1:0] want_v,
                              input logic [WORD_W-1:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      end
   endtask

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin : check_rsp
      key_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_key_words.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, kind %0d data %0h", $time,
                     rsp_tuser, rsp_tdata);
         end else begin
            want = expected_key_words.pop_front();
            check_field("kind", WORD_W'(want.kind), WORD_W'(rsp_tuser));
            check_field("data_byte", WORD_W'(want.data), WORD_W'(rsp_tdata[7:0]));
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_tdata[10:8]));
            check_field("modulus_len", want.mod_len, rsp_tdata[42:11]);
            check_field("exponent_len", want.exp_len, rsp_tdata[74:43]);
            check_field("pad bits", '0, WORD_W'(rsp_tdata[79:75]));
            check_field("last_out", WORD_W'(want.last), WORD_W'(rsp_tlast));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      byte_q_type   key;
      int unsigned  phase_words;
      key_word_type typed_word;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 69;
      restart_key();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; a typed status replaces the modeled one
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].data, directed_rows[i].last);
         if (directed_rows[i].typed) begin
            void'(expected_key_words.pop_back());
            typed_word = '{KIND_STATUS, 8'h00, directed_rows[i].status, '0, '0, 1'b1};
            expected_key_words.push_back(typed_word);
         end
      end

      // random keys under three idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (ph != 1) hold_off_left = HOLD_OFF;
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            make_key(key);
            foreach (key[i]) send_word(key[i], i == key.size() - 1);
            phase_words += key.size();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then wait for stray words
      while (expected_key_words.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_key_words.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
